// File: hw/rtl/chirp_tone_voice_with_fade_defines.svh
// ----------------------------------------------------------------------------
// Chirp tone voice assertion macros
// Concurrent assertion helpers for the top-level RTL file of the voice.
// ----------------------------------------------------------------------------
`ifndef CHIRP_TONE_VOICE_WITH_FADE_DEFINES_SVH
`define CHIRP_TONE_VOICE_WITH_FADE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked outside reset.
`define CTWF_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("chirp voice assertion failed");
// Next-cycle implication, checked outside reset.
`define CTWF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("chirp voice assertion failed");
`else
`define CTWF_ASSERT_IMPL(label, ante, cons)
`define CTWF_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: hw/rtl/ctwf_pkg.sv
// ----------------------------------------------------------------------------
// Chirp tone voice package
// Shared widths, register indexes, microcode fields and control types.
// ----------------------------------------------------------------------------
package ctwf_pkg;

    localparam int PC_W       = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 21;
    localparam int NOTE_W     = 8;
    localparam int SAMPLE_W   = 15;
    localparam int FREQ_W     = 16;
    localparam int SLOW_W     = 8;
    localparam int VOL_W      = 8;
    localparam int LEN_W      = 16;
    localparam int FSTEP_W    = 21;
    localparam int QUO_W      = 7;
    localparam int AMP_W      = 15;
    localparam int FADE_SHIFT = 20;
    localparam int FACT_W     = 21;
    localparam int DIV_BASE   = 10000;
    localparam int TONE_W     = 24;   // start_freq times note

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_START_FREQ  = 3'd0;
    localparam t_cfg_idx CFG_SLOWDOWN    = 3'd1;
    localparam t_cfg_idx CFG_VOLUME      = 3'd2;
    localparam t_cfg_idx CFG_NOTE_LENGTH = 3'd3;
    localparam t_cfg_idx CFG_FADE_START  = 3'd4;
    localparam t_cfg_idx CFG_FADE_STEP   = 3'd5;

    localparam logic [FREQ_W-1:0]  RST_START_FREQ  = 16'd10500;
    localparam logic [SLOW_W-1:0]  RST_SLOWDOWN    = 8'd12;
    localparam logic [VOL_W-1:0]   RST_VOLUME      = 8'd180;
    localparam logic [LEN_W-1:0]   RST_NOTE_LENGTH = 16'd18522;
    localparam logic [LEN_W-1:0]   RST_FADE_START  = 16'd15435;
    localparam logic [FSTEP_W-1:0] RST_FADE_STEP   = 21'd339;

    localparam logic [FACT_W-1:0]  FACT_ONE = 21'h100000;

    // Multiplier operand A sources.
    typedef logic [2:0] t_mul_a;
    localparam t_mul_a MA_FREQ  = 3'd0;
    localparam t_mul_a MA_PROD  = 3'd1;
    localparam t_mul_a MA_POS   = 3'd2;
    localparam t_mul_a MA_QUO   = 3'd3;
    localparam t_mul_a MA_FSTEP = 3'd4;
    localparam t_mul_a MA_AMP   = 3'd5;

    // Multiplier operand B sources.
    typedef logic [2:0] t_mul_b;
    localparam t_mul_b MB_NOTE = 3'd0;
    localparam t_mul_b MB_POS  = 3'd1;
    localparam t_mul_b MB_SLOW = 3'd2;
    localparam t_mul_b MB_VOL  = 3'd3;
    localparam t_mul_b MB_DIFF = 3'd4;
    localparam t_mul_b MB_FACT = 3'd5;

    // Jump conditions.
    typedef logic [2:0] t_cond;
    localparam t_cond COND_NEVER    = 3'd0;
    localparam t_cond COND_NO_IN    = 3'd1;
    localparam t_cond COND_DIV_MORE = 3'd2;
    localparam t_cond COND_NO_FADE  = 3'd3;
    localparam t_cond COND_OUT_BUSY = 3'd4;

    typedef struct packed {
        logic            take_in;
        t_mul_a          mul_a;
        t_mul_b          mul_b;
        logic            mul_en;
        logic            ld_num;
        logic            div_init;
        logic            div_step;
        logic            ld_amp;
        logic            ld_fact;
        logic            ld_fade;
        logic            out_load;
        t_cond           cond;
        logic [PC_W-1:0] target;
        logic            last;
    } t_ctl;

    typedef struct packed {
        logic in_acc;
        logic div_more;
        logic no_fade;
        logic out_busy;
    } t_status;

endpackage

// File: hw/rtl/chirp_tone_voice_with_fade.sv
// ----------------------------------------------------------------------------
// Chirp tone voice with fade
// Sample generator: chirped tone quotient, volume scaling and linear fade-out.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+-------------------------
//   input   | in        | i_in_valid / o_in_stall   | i_note, i_restart
//   output  | out       | o_out_valid / i_out_stall | o_sample, o_note_end
//   config  | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// Each sample runs the bit-serial divider, which spends one cycle per numerator
// bit, plus the shared multiplier steps; the fade steps run only once the
// position is past the fade start.
// Reset is synchronous and restores the register defaults and position zero.
// A new beat is taken while the previous result waits in the output register;
// the final step holds only while that register is still full and stalled.
// ----------------------------------------------------------------------------
`include "chirp_tone_voice_with_fade_defines.svh"

module chirp_tone_voice_with_fade #(
    parameter int POS_WIDTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [ctwf_pkg::NOTE_W-1:0]      i_note,
    input  logic                             i_restart,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [ctwf_pkg::SAMPLE_W-1:0]    o_sample,
    output logic                             o_note_end,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [ctwf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ctwf_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int AW     = (POS_WIDTH > ctwf_pkg::TONE_W) ? POS_WIDTH : ctwf_pkg::TONE_W;
    localparam int BW     = (POS_WIDTH > ctwf_pkg::FACT_W) ? POS_WIDTH : ctwf_pkg::FACT_W;
    localparam int PW     = AW + BW;
    localparam int NUM_W  = ctwf_pkg::TONE_W + POS_WIDTH;
    localparam int DEN_W  = POS_WIDTH + ctwf_pkg::SLOW_W + 1;
    localparam int DEC_W  = ctwf_pkg::FSTEP_W + POS_WIDTH;
    localparam int CMP_W  = (POS_WIDTH + 1 > ctwf_pkg::LEN_W) ? POS_WIDTH + 1 : ctwf_pkg::LEN_W;
    localparam int CNT_W  = $clog2(NUM_W + 1);

    // Configuration registers.
    logic [ctwf_pkg::FREQ_W-1:0]  r_start_freq;
    logic [ctwf_pkg::SLOW_W-1:0]  r_slowdown;
    logic [ctwf_pkg::VOL_W-1:0]   r_volume;
    logic [ctwf_pkg::LEN_W-1:0]   r_note_length;
    logic [ctwf_pkg::LEN_W-1:0]   r_fade_start;
    logic [ctwf_pkg::FSTEP_W-1:0] r_fade_step;

    // Voice state and working registers.
    logic [POS_WIDTH-1:0]         r_state;
    logic [POS_WIDTH-1:0]         n_state;
    logic [POS_WIDTH-1:0]         r_pos;
    logic [ctwf_pkg::NOTE_W-1:0]  r_note;
    logic                         r_last;
    logic [PW-1:0]                r_mul;
    logic [NUM_W-1:0]             r_num;
    logic [DEN_W-1:0]             r_den;
    logic [DEN_W-1:0]             r_rem;
    logic [ctwf_pkg::QUO_W-1:0]   r_quo;
    logic [CNT_W-1:0]             r_cnt;
    logic [ctwf_pkg::AMP_W-1:0]   r_amp;
    logic [ctwf_pkg::FACT_W-1:0]  r_fact;
    logic                         r_out_valid;
    logic [ctwf_pkg::SAMPLE_W-1:0] r_sample;
    logic                         r_note_end;

    ctwf_pkg::t_ctl    ctl;
    ctwf_pkg::t_status status;

    logic                in_acc;
    logic                out_busy;
    logic [POS_WIDTH-1:0] pos_cur;
    logic [CMP_W-1:0]    pos_next;
    logic                last;
    logic [CMP_W-1:0]    pos_ext;
    logic [CMP_W-1:0]    fs_ext;
    logic [CMP_W-1:0]    diff_ext;
    logic [AW-1:0]       mul_a;
    logic [BW-1:0]       mul_b;
    logic [DEN_W:0]      rem_sh;
    logic [DEN_W:0]      rem_sub;
    logic                q_bit;
    logic [ctwf_pkg::FACT_W-1:0] fact_n;

    ctwf_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_ctl    (ctl)
    );

    assign o_in_stall  = !ctl.take_in;
    assign in_acc      = i_in_valid && ctl.take_in;
    assign out_busy    = r_out_valid && i_out_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_sample    = r_sample;
    assign o_note_end  = r_note_end;

    // Position bookkeeping happens as the beat is taken.
    always_comb begin
        pos_cur  = i_restart ? '0 : r_state;
        pos_next = CMP_W'(pos_cur) + 1'b1;
        last     = pos_next >= CMP_W'(r_note_length);
        n_state  = last ? '0 : pos_next[POS_WIDTH-1:0];
    end

    assign pos_ext  = CMP_W'(r_pos);
    assign fs_ext   = CMP_W'(r_fade_start);
    assign diff_ext = pos_ext - fs_ext;

    assign status.in_acc   = in_acc;
    assign status.div_more = r_cnt != CNT_W'(1);
    assign status.no_fade  = pos_ext <= fs_ext;
    assign status.out_busy = out_busy;

    always_comb begin
        case (ctl.mul_a)
            ctwf_pkg::MA_FREQ:  mul_a = AW'(r_start_freq);
            ctwf_pkg::MA_PROD:  mul_a = AW'(r_mul[ctwf_pkg::TONE_W-1:0]);
            ctwf_pkg::MA_POS:   mul_a = AW'(r_pos);
            ctwf_pkg::MA_QUO:   mul_a = AW'(r_quo);
            ctwf_pkg::MA_FSTEP: mul_a = AW'(r_fade_step);
            ctwf_pkg::MA_AMP:   mul_a = AW'(r_amp);
            default:            mul_a = '0;
        endcase
        case (ctl.mul_b)
            ctwf_pkg::MB_NOTE: mul_b = BW'(r_note);
            ctwf_pkg::MB_POS:  mul_b = BW'(r_pos);
            ctwf_pkg::MB_SLOW: mul_b = BW'(r_slowdown);
            ctwf_pkg::MB_VOL:  mul_b = BW'(r_volume);
            ctwf_pkg::MB_DIFF: mul_b = BW'(diff_ext[POS_WIDTH-1:0]);
            ctwf_pkg::MB_FACT: mul_b = BW'(r_fact);
            default:           mul_b = '0;
        endcase
    end

    // Restoring division, one quotient bit per step; only the low bits are kept.
    always_comb begin
        rem_sh  = {r_rem, r_num[NUM_W-1]};
        rem_sub = rem_sh - {1'b0, r_den};
        q_bit   = rem_sh >= {1'b0, r_den};
    end

    // The fade factor saturates at zero once the decrement reaches one.
    assign fact_n = (|r_mul[DEC_W-1:ctwf_pkg::FADE_SHIFT]) ? '0 :
                    ctwf_pkg::FACT_ONE - {1'b0, r_mul[ctwf_pkg::FADE_SHIFT-1:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_freq  <= ctwf_pkg::RST_START_FREQ;
            r_slowdown    <= ctwf_pkg::RST_SLOWDOWN;
            r_volume      <= ctwf_pkg::RST_VOLUME;
            r_note_length <= ctwf_pkg::RST_NOTE_LENGTH;
            r_fade_start  <= ctwf_pkg::RST_FADE_START;
            r_fade_step   <= ctwf_pkg::RST_FADE_STEP;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ctwf_pkg::CFG_START_FREQ:  r_start_freq  <= i_cfg_data[ctwf_pkg::FREQ_W-1:0];
                ctwf_pkg::CFG_SLOWDOWN:    r_slowdown    <= i_cfg_data[ctwf_pkg::SLOW_W-1:0];
                ctwf_pkg::CFG_VOLUME:      r_volume      <= i_cfg_data[ctwf_pkg::VOL_W-1:0];
                ctwf_pkg::CFG_NOTE_LENGTH: r_note_length <= i_cfg_data[ctwf_pkg::LEN_W-1:0];
                ctwf_pkg::CFG_FADE_START:  r_fade_start  <= i_cfg_data[ctwf_pkg::LEN_W-1:0];
                ctwf_pkg::CFG_FADE_STEP:   r_fade_step   <= i_cfg_data[ctwf_pkg::FSTEP_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_state <= n_state;
            end
            if (ctl.out_load && !out_busy) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_pos  <= pos_cur;
            r_note <= i_note;
            r_last <= last;
        end
        if (ctl.mul_en) begin
            r_mul <= PW'(mul_a) * PW'(mul_b);
        end
        if (ctl.ld_num) begin
            r_num <= r_mul[NUM_W-1:0];
        end
        if (ctl.div_init) begin
            r_den <= DEN_W'(ctwf_pkg::DIV_BASE) + DEN_W'(r_mul[POS_WIDTH+ctwf_pkg::SLOW_W-1:0]);
            r_rem <= '0;
            r_cnt <= CNT_W'(NUM_W);
        end
        if (ctl.div_step) begin
            r_rem <= q_bit ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            r_num <= {r_num[NUM_W-2:0], 1'b0};
            r_quo <= {r_quo[ctwf_pkg::QUO_W-2:0], q_bit};
            r_cnt <= r_cnt - 1'b1;
        end
        if (ctl.ld_amp) begin
            r_amp <= r_mul[ctwf_pkg::AMP_W-1:0];
        end
        if (ctl.ld_fact) begin
            r_fact <= fact_n;
        end
        if (ctl.ld_fade) begin
            r_amp <= r_mul[ctwf_pkg::FADE_SHIFT+ctwf_pkg::AMP_W-1:ctwf_pkg::FADE_SHIFT];
        end
        if (ctl.out_load && !out_busy) begin
            r_sample   <= r_amp;
            r_note_end <= r_last;
        end
    end

    `CTWF_ASSERT_NEXT(a_stall_after_take, in_acc, o_in_stall)
    `CTWF_ASSERT_NEXT(a_restart_zero, in_acc && i_restart, r_pos == '0)
    `CTWF_ASSERT_IMPL(a_div_count_live, ctl.div_step, r_cnt != '0)
    `CTWF_ASSERT_NEXT(a_load_sets_valid, ctl.out_load && !out_busy, o_out_valid)

endmodule

// File: hw/rtl/ctwf_seq.sv
// ----------------------------------------------------------------------------
// Chirp tone voice sequencer
// Step counter and microcode table that drive the voice datapath.
// ----------------------------------------------------------------------------
module ctwf_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ctwf_pkg::t_status i_status,
    output ctwf_pkg::t_ctl    o_ctl
);

    localparam logic [ctwf_pkg::PC_W-1:0] STEP_IDLE     = 4'd0;
    localparam logic [ctwf_pkg::PC_W-1:0] STEP_TONE     = 4'd1;
    localparam logic [ctwf_pkg::PC_W-1:0] STEP_NUM      = 4'd2;
    localparam logic [ctwf_pkg::PC_W-1:0] STEP_DEN      = 4'd3;
    localparam logic [ctwf_pkg::PC_W-1:0] STEP_DIV_INIT = 4'd4;
    localparam logic [ctwf_pkg::PC_W-1:0] STEP_DIV      = 4'd5;
    localparam logic [ctwf_pkg::PC_W-1:0] STEP_VOL      = 4'd6;
    localparam logic [ctwf_pkg::PC_W-1:0] STEP_DEC      = 4'd7;
    localparam logic [ctwf_pkg::PC_W-1:0] STEP_FACT     = 4'd8;
    localparam logic [ctwf_pkg::PC_W-1:0] STEP_FADE_MUL = 4'd9;
    localparam logic [ctwf_pkg::PC_W-1:0] STEP_FADE     = 4'd10;
    localparam logic [ctwf_pkg::PC_W-1:0] STEP_OUT      = 4'd11;

    function automatic ctwf_pkg::t_ctl rom(input logic [ctwf_pkg::PC_W-1:0] pc);
        ctwf_pkg::t_ctl w;
        w = '0;
        case (pc)
            STEP_IDLE: begin
                w.take_in = 1'b1;
                w.cond    = ctwf_pkg::COND_NO_IN;
                w.target  = STEP_IDLE;
            end
            STEP_TONE: begin
                w.mul_en = 1'b1;
                w.mul_a  = ctwf_pkg::MA_FREQ;
                w.mul_b  = ctwf_pkg::MB_NOTE;
            end
            STEP_NUM: begin
                w.mul_en = 1'b1;
                w.mul_a  = ctwf_pkg::MA_PROD;
                w.mul_b  = ctwf_pkg::MB_POS;
            end
            STEP_DEN: begin
                w.ld_num = 1'b1;
                w.mul_en = 1'b1;
                w.mul_a  = ctwf_pkg::MA_POS;
                w.mul_b  = ctwf_pkg::MB_SLOW;
            end
            STEP_DIV_INIT: begin
                w.div_init = 1'b1;
            end
            STEP_DIV: begin
                w.div_step = 1'b1;
                w.cond     = ctwf_pkg::COND_DIV_MORE;
                w.target   = STEP_DIV;
            end
            STEP_VOL: begin
                w.mul_en = 1'b1;
                w.mul_a  = ctwf_pkg::MA_QUO;
                w.mul_b  = ctwf_pkg::MB_VOL;
            end
            STEP_DEC: begin
                w.ld_amp = 1'b1;
                w.mul_en = 1'b1;
                w.mul_a  = ctwf_pkg::MA_FSTEP;
                w.mul_b  = ctwf_pkg::MB_DIFF;
                w.cond   = ctwf_pkg::COND_NO_FADE;
                w.target = STEP_OUT;
            end
            STEP_FACT: begin
                w.ld_fact = 1'b1;
            end
            STEP_FADE_MUL: begin
                w.mul_en = 1'b1;
                w.mul_a  = ctwf_pkg::MA_AMP;
                w.mul_b  = ctwf_pkg::MB_FACT;
            end
            STEP_FADE: begin
                w.ld_fade = 1'b1;
            end
            STEP_OUT: begin
                w.out_load = 1'b1;
                w.cond     = ctwf_pkg::COND_OUT_BUSY;
                w.target   = STEP_OUT;
                w.last     = 1'b1;
            end
            default: begin
                w.last = 1'b1;
            end
        endcase
        return w;
    endfunction

    logic [ctwf_pkg::PC_W-1:0] r_pc;
    logic [ctwf_pkg::PC_W-1:0] n_pc;
    logic                      jump;

    assign o_ctl = rom(r_pc);

    always_comb begin
        case (o_ctl.cond)
            ctwf_pkg::COND_NEVER:    jump = 1'b0;
            ctwf_pkg::COND_NO_IN:    jump = !i_status.in_acc;
            ctwf_pkg::COND_DIV_MORE: jump = i_status.div_more;
            ctwf_pkg::COND_NO_FADE:  jump = i_status.no_fade;
            ctwf_pkg::COND_OUT_BUSY: jump = i_status.out_busy;
            default:                 jump = 1'b0;
        endcase
        if (jump) begin
            n_pc = o_ctl.target;
        end else if (o_ctl.last) begin
            n_pc = STEP_IDLE;
        end else begin
            n_pc = r_pc + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= STEP_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule
